@@ sv/kpd_pkg.sv @@
// Shared types, key codes, register indexes and reset values for the keypad scanner.
package kpd_pkg;

  localparam int unsigned KeyCount = 7;

  typedef logic [KeyCount-1:0] keys_t;
  typedef logic [2:0]          key_code_t;
  typedef logic [7:0]          count_t;
  typedef logic [1:0]          cfg_index_t;
  typedef logic [7:0]          cfg_data_t;

  localparam key_code_t CODE_NONE  = 3'd0;
  localparam key_code_t CODE_M     = 3'd1;
  localparam key_code_t CODE_B     = 3'd2;
  localparam key_code_t CODE_PLAY  = 3'd3;
  localparam key_code_t CODE_UP    = 3'd4;
  localparam key_code_t CODE_DOWN  = 3'd5;
  localparam key_code_t CODE_LEFT  = 3'd6;
  localparam key_code_t CODE_RIGHT = 3'd7;

  localparam cfg_index_t CFG_VERTICAL_MODE      = 2'd0;
  localparam cfg_index_t CFG_SCAN_PERIOD        = 2'd1;
  localparam cfg_index_t CFG_FIRST_REPEAT_DELAY = 2'd2;
  localparam cfg_index_t CFG_REPEAT_INTERVAL    = 2'd3;

  localparam count_t SCAN_PERIOD_RST        = 8'd10;
  localparam count_t FIRST_REPEAT_DELAY_RST = 8'd25;
  localparam count_t REPEAT_INTERVAL_RST    = 8'd2;

  // Priority encode: lowest pin wins; arrows swap round in vertical orientation.
  function automatic key_code_t encode_keys(input keys_t keys, input logic vertical);
    key_code_t code;
    code = CODE_NONE;
    priority if (keys[0]) code = CODE_M;
    else if (keys[1]) code = CODE_B;
    else if (keys[2]) code = CODE_PLAY;
    else if (keys[3]) code = vertical ? CODE_RIGHT : CODE_UP;
    else if (keys[4]) code = vertical ? CODE_LEFT  : CODE_DOWN;
    else if (keys[5]) code = vertical ? CODE_UP    : CODE_LEFT;
    else if (keys[6]) code = vertical ? CODE_DOWN  : CODE_RIGHT;
    else              code = CODE_NONE;
    return code;
  endfunction

endpackage

@@ sv/kpd_ifs.sv @@
// Valid/ready channel interfaces for tick input, key code output and register writes.
interface kpd_in_if
  import kpd_pkg::*;
();
  logic  valid;
  logic  ready;
  keys_t keys_pressed;

  modport source (output valid, output keys_pressed, input ready);
  modport sink   (input valid, input keys_pressed, output ready);
endinterface

interface kpd_out_if
  import kpd_pkg::*;
();
  logic      valid;
  logic      ready;
  key_code_t key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

interface kpd_cfg_if
  import kpd_pkg::*;
();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/keypad_scan_autorepeat.sv @@
// Keypad scanner with prescaler, priority encoder and typematic autorepeat.
//
//  channel  | direction | payload                 | beat taken when
//  ---------+-----------+-------------------------+----------------------------
//  in_ch    | sink      | keys_pressed  [6:0]     | valid && ready
//  out_ch   | source    | key_code      [2:0]     | valid && ready
//  cfg_ch   | sink      | index [1:0], data [7:0] | valid && ready (ready tied 1)
//
// One tick beat per cycle while in_ch is not stalled; the state update happens in the cycle
// the beat is taken, and any key code is registered into the output register or the skid.
// An output register plus a one-entry skid keeps in_ch open while a code waits;
// in_ch stalls only when both hold a code.
// Synchronous active-low reset restores the register reset values, reloads the
// prescaler with 10 and clears the key history and repeat counters.
module keypad_scan_autorepeat
  import kpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  kpd_in_if.sink    in_ch,
  kpd_out_if.source out_ch,
  kpd_cfg_if.sink   cfg_ch
);

  // configuration registers
  logic      vertical_mode_r;
  count_t    scan_period_r;
  count_t    first_repeat_delay_r;
  count_t    repeat_interval_r;

  // scan state
  count_t    tick_count_r, tick_count_nxt;
  key_code_t last_key_r, last_key_nxt;
  count_t    wait_count_r, wait_count_nxt;
  logic      menu_done_r, menu_done_nxt;

  // output register and skid
  logic      out_valid_r;
  key_code_t out_code_r;
  logic      skid_valid_r;
  key_code_t skid_code_r;

  logic      accept;
  logic      emit;
  key_code_t emit_code;
  key_code_t code;
  count_t    tick_dec;
  count_t    wait_dec;
  logic      scan;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !skid_valid_r;
  assign accept       = in_ch.valid && in_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.key_code = out_code_r;

  always_comb begin
    tick_dec       = tick_count_r - {7'd0, |tick_count_r};
    scan           = (tick_dec == '0);
    wait_dec       = wait_count_r - {7'd0, |wait_count_r};
    code           = encode_keys(in_ch.keys_pressed, vertical_mode_r);
    tick_count_nxt = scan ? scan_period_r : tick_dec;
    wait_count_nxt = wait_count_r;
    last_key_nxt   = last_key_r;
    menu_done_nxt  = menu_done_r;
    emit           = 1'b0;
    emit_code      = code;
    if (scan) begin
      wait_count_nxt = wait_dec;
      last_key_nxt   = code;
      if (code != CODE_NONE) begin
        if (code != last_key_r) begin
          // new key: emit, arm the first-repeat delay
          wait_count_nxt = first_repeat_delay_r;
          menu_done_nxt  = 1'b0;
          emit           = 1'b1;
        end else if (wait_dec == '0) begin
          if (code >= CODE_UP) begin
            wait_count_nxt = repeat_interval_r;
            emit           = 1'b1;
          end else if (code == CODE_M && !menu_done_r) begin
            // held M gives B once
            menu_done_nxt = 1'b1;
            emit          = 1'b1;
            emit_code     = CODE_B;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertical_mode_r      <= 1'b0;
      scan_period_r        <= SCAN_PERIOD_RST;
      first_repeat_delay_r <= FIRST_REPEAT_DELAY_RST;
      repeat_interval_r    <= REPEAT_INTERVAL_RST;
      tick_count_r         <= SCAN_PERIOD_RST;
      last_key_r           <= CODE_NONE;
      wait_count_r         <= '0;
      menu_done_r          <= 1'b0;
      out_valid_r          <= 1'b0;
      skid_valid_r         <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_VERTICAL_MODE:      vertical_mode_r      <= cfg_ch.data[0];
          CFG_SCAN_PERIOD:        scan_period_r        <= cfg_ch.data;
          CFG_FIRST_REPEAT_DELAY: first_repeat_delay_r <= cfg_ch.data;
          CFG_REPEAT_INTERVAL:    repeat_interval_r    <= cfg_ch.data;
          default:                ;
        endcase
      end
      if (accept) begin
        tick_count_r <= tick_count_nxt;
        last_key_r   <= last_key_nxt;
        wait_count_r <= wait_count_nxt;
        menu_done_r  <= menu_done_nxt;
      end
      // advance the output register; park a new beat in the skid if it is held
      if (!out_valid_r || out_ch.ready) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= accept && emit;
        end
      end else if (accept && emit) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_code_r <= skid_valid_r ? skid_code_r : emit_code;
    end else if (accept && emit) begin
      skid_code_r <= emit_code;
    end
  end

endmodule

@@ dv/tb_keypad_scan_autorepeat.sv @@
// Self-checking testbench for the keypad scanner: directed key cases, then random key traffic.
module tb_keypad_scan_autorepeat;
  import kpd_pkg::*;

  localparam int IdleLimit = 1000;

  logic clk;
  logic rst_n;

  kpd_in_if  in_ch ();
  kpd_out_if out_ch ();
  kpd_cfg_if cfg_ch ();

  keypad_scan_autorepeat dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Scanner mirror: register copies and scan state.
  logic      vertical_reg;
  count_t    period_reg;
  count_t    delay_reg;
  count_t    interval_reg;
  count_t    tick_left;
  key_code_t last_code;
  count_t    repeat_wait;
  logic      menu_b_sent;

  const key_code_t landscape_map [KeyCount] =
    '{CODE_M, CODE_B, CODE_PLAY, CODE_UP, CODE_DOWN, CODE_LEFT, CODE_RIGHT};
  const key_code_t portrait_map [KeyCount] =
    '{CODE_M, CODE_B, CODE_PLAY, CODE_RIGHT, CODE_LEFT, CODE_UP, CODE_DOWN};

  key_code_t predicted_codes [$];
  int        ticks_sent;
  int        errors;
  int        idle_cycles;
  int        in_gap_odds;
  logic      quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void step_scanner(input keys_t keys);
    key_code_t code;
    code = CODE_NONE;
    if (tick_left != 0) tick_left--;
    if (tick_left != 0) return;
    tick_left = period_reg;
    if (repeat_wait != 0) repeat_wait--;
    // walk downward so the lowest pressed pin has the last word
    for (int b = KeyCount - 1; b >= 0; b--) begin
      if (keys[b]) code = vertical_reg ? portrait_map[b] : landscape_map[b];
    end
    if (code != CODE_NONE) begin
      if (code != last_code) begin
        repeat_wait = delay_reg;
        menu_b_sent = 1'b0;
        predicted_codes.push_back(code);
      end else if (repeat_wait == 0) begin
        if (code >= CODE_UP) begin
          repeat_wait = interval_reg;
          predicted_codes.push_back(code);
        end else if (code == CODE_M && !menu_b_sent) begin
          menu_b_sent = 1'b1;
          predicted_codes.push_back(CODE_B);
        end
      end
    end
    last_code = code;
  endfunction

  task automatic send_tick(input keys_t keys);
    in_ch.valid        <= 1'b1;
    in_ch.keys_pressed <= keys;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    step_scanner(keys);
    ticks_sent++;
    if (!quiet && in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Hold the tick stream until every predicted code has left the block.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (predicted_codes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_VERTICAL_MODE:      vertical_reg = val[0];
      CFG_SCAN_PERIOD:        period_reg = val;
      CFG_FIRST_REPEAT_DELAY: delay_reg = val;
      CFG_REPEAT_INTERVAL:    interval_reg = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic vert, input count_t period, input count_t delay,
                                input count_t interval);
    quiesce();
    write_reg(CFG_VERTICAL_MODE, cfg_data_t'(vert));
    write_reg(CFG_SCAN_PERIOD, period);
    write_reg(CFG_FIRST_REPEAT_DELAY, delay);
    write_reg(CFG_REPEAT_INTERVAL, interval);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    // tenth tick is the first scan at reset settings
    repeat (11) send_tick(7'h04);
  endtask

  task automatic test_key_priority();
    apply_settings(1'b0, 8'd0, 8'd255, 8'd255);
    // run the prescaler down so every following tick scans
    while (tick_left > 1) send_tick('0);
    send_tick(7'h7F);
    send_tick(7'h7E);
    send_tick(7'h7C);
    send_tick(7'h78);
    send_tick(7'h70);
    send_tick(7'h60);
    send_tick(7'h40);
    send_tick(7'h00);
  endtask

  task automatic test_portrait_remap();
    apply_settings(1'b1, 8'd0, 8'd255, 8'd255);
    send_tick(7'h08);
    send_tick(7'h10);
    send_tick(7'h20);
    send_tick(7'h40);
    send_tick(7'h00);
  endtask

  task automatic test_zero_delays();
    apply_settings(1'b0, 8'd0, 8'd0, 8'd0);
    repeat (3) send_tick(7'h40);
    // held menu key gives one B, then nothing
    repeat (3) send_tick(7'h01);
    repeat (2) send_tick(7'h02);
  endtask

  task automatic test_long_period();
    apply_settings(1'b1, 8'd255, 8'd1, 8'd0);
    repeat (520) send_tick(7'h20);
  endtask

  task automatic play_phase(input int n);
    int    sent;
    int    kind;
    int    run;
    int    top;
    keys_t k;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // hold one key on top, lower-priority pins free
        top = $urandom_range(0, KeyCount - 1);
        run = $urandom_range(1, 12) * ((period_reg == 0) ? 1 : int'(period_reg));
        if (run > 48) run = 48;
        repeat (run) begin
          k = keys_t'($urandom);
          for (int b = 0; b < top; b++) k[b] = 1'b0;
          k[top] = 1'b1;
          send_tick(k);
        end
      end else if (kind == 7) begin
        run = $urandom_range(1, 6);
        repeat (run) send_tick('0);
      end else begin
        run = $urandom_range(1, 8);
        repeat (run) send_tick(keys_t'($urandom));
      end
      sent += run;
    end
  endtask

  function automatic count_t pick_delay();
    case ($urandom_range(0, 9))
      7, 8:    return count_t'($urandom_range(7, 40));
      9:       return ($urandom_range(0, 1) != 0) ? 8'd255 : count_t'($urandom);
      default: return count_t'($urandom_range(0, 6));
    endcase
  endfunction

  task automatic test_random_traffic();
    int     start_ticks;
    count_t period;
    start_ticks = ticks_sent;
    while (ticks_sent - start_ticks < 850) begin
      case ($urandom_range(0, 9))
        6, 7, 8: period = count_t'($urandom_range(4, 12));
        9:       period = count_t'($urandom_range(13, 40));
        default: period = count_t'($urandom_range(0, 3));
      endcase
      apply_settings(logic'($urandom_range(0, 1)), period, pick_delay(), pick_delay());
      case ($urandom_range(0, 2))
        0:       in_gap_odds = 0;
        1:       in_gap_odds = 3;
        default: in_gap_odds = 8;
      endcase
      // drop all idling for the tail of the run
      if (ticks_sent - start_ticks >= 650) quiet = 1'b1;
      play_phase(120);
    end
  endtask

  always @(posedge clk) begin : check_codes
    key_code_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_codes.size() == 0) begin
        errors++;
        $display("%0t: key code mismatch, expected none, actual %0d",
                 $time, out_ch.key_code);
      end else begin
        want = predicted_codes.pop_front();
        if (out_ch.key_code !== want) begin
          errors++;
          $display("%0t: key code mismatch, expected %0d, actual %0d",
                   $time, want, out_ch.key_code);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("%0t: no beat for %0d cycles", $time, IdleLimit);
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  initial begin
    vertical_reg    = 1'b0;
    period_reg      = SCAN_PERIOD_RST;
    delay_reg       = FIRST_REPEAT_DELAY_RST;
    interval_reg    = REPEAT_INTERVAL_RST;
    tick_left       = SCAN_PERIOD_RST;
    last_code       = CODE_NONE;
    repeat_wait     = '0;
    menu_b_sent     = 1'b0;
    ticks_sent      = 0;
    errors          = 0;
    idle_cycles     = 0;
    in_gap_odds     = 4;
    quiet           = 1'b0;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.keys_pressed <= '0;
    out_ch.ready       <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_VERTICAL_MODE;
    cfg_ch.data        <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_key_priority();
    test_portrait_remap();
    test_zero_delays();
    test_long_period();
    test_random_traffic();

    quiesce();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
